// ===== hw/rtl/dlbv_pkg.sv =====
`timescale 1ns / 1ps
package dlbv_pkg;

   localparam int LinesPerFrame = 307;
   localparam int BlankLines    = 19;
   localparam int LinePixels    = 640;

   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_PLANE = 2'd1;
   localparam logic [1:0] KIND_PIXEL = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [15:0] LIST_START_RESET = 16'd184;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_TAG1  = 6'b000010,
      PH_TAG2  = 6'b000100,
      PH_BITS  = 6'b001000,
      PH_LINK  = 6'b010000,
      PH_PLANE = 6'b100000
   } phase_type;

   // Colour table: index is bank (bits 6..4) and YRGB nibble (bits 3..0).
   function automatic logic [23:0] colour_lookup(input logic [6:0] idx);
      logic       bank_r;
      logic       bank_g;
      logic       bank_b;
      logic [7:0] hi_r, hi_g, hi_b, lo_r, lo_g, lo_b;
      logic [7:0] r, g, b;
      bank_b = idx[4];
      bank_g = idx[5];
      bank_r = idx[6];
      lo_b = bank_b ? 8'h60 : 8'h80;
      hi_b = bank_b ? 8'hDF : 8'hFF;
      lo_g = bank_g ? 8'h60 : 8'h80;
      hi_g = bank_g ? 8'hDF : 8'hFF;
      lo_r = bank_r ? 8'h60 : 8'h80;
      hi_r = bank_r ? 8'hDF : 8'hFF;
      b = idx[0] ? (idx[3] ? hi_b : lo_b) : 8'h00;
      g = idx[1] ? (idx[3] ? hi_g : lo_g) : 8'h00;
      r = idx[2] ? (idx[3] ? hi_r : lo_r) : 8'h00;
      return {r, g, b};
   endfunction

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] address;
      logic [23:0] rgb;
      logic [3:0]  rep;
      logic [8:0]  row;
      logic        last;
   } result_type;

endpackage

// ===== hw/rtl/display_list_bitplane_video.sv =====
`timescale 1ns / 1ps
// Channel | direction | ports
// req     | in        | req_valid/req_ready, req_type, word_data, plane0..2_byte
// rsp     | out       | rsp_valid/rsp_ready, kind, address, pixel_rgb, repeat_res, row, last
// csr     | in        | csr_we, csr_wdata (list_start)
//
// A word reply gives one result word in the cycle after it is taken, so word
// replies can be taken on every cycle while rsp is not stalled and no rebuild
// runs. A plane reply gives eight pixel runs; each run needs a palette read and
// then an output cycle, one run after the other, and the read or line-end word
// follows. No word is taken until the runs are done. The current palette sits
// in an eight-entry memory; after the second tag and after a frame start it is
// rebuilt one entry per cycle, while no word is taken. Reset is synchronous and
// clears control state; a stalled rsp holds the output, new words and runs, but not a rebuild.
module display_list_bitplane_video (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] word_data,
   input  logic [7:0]  plane0_byte,
   input  logic [7:0]  plane1_byte,
   input  logic [7:0]  plane2_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  kind,
   output logic [15:0] address,
   output logic [23:0] pixel_rgb,
   output logic [3:0]  repeat_res,
   output logic [8:0]  row,
   output logic        last,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   logic [15:0] list_start_ff;
   dlbv_pkg::phase_type phase_ff, phase_in;
   logic [8:0]  line_ff, line_in;
   logic [15:0] list_ff, list_in, bmap_ff, bmap_in, tag1_ff, tag1_in;
   logic        size_ff, size_in, typ_ff, typ_in;
   logic [31:0] palw_ff, palw_in;
   logic [3:0]  scale_ff, scale_in, ccol_ff, ccol_in;
   logic [6:0]  bank_ff, bank_in;
   logic        ctype_ff, ctype_in, con_ff, con_in;
   logic [7:0]  cpos_ff, cpos_in;
   logic [2:0]  cbit_ff, cbit_in;
   logic [10:0] left_ff, left_in;
   logic [9:0]  bpos_ff, bpos_in;

   // Pixel burst: eight runs of a plane word.
   logic        burst_ff, burst_in;
   logic [3:0]  bidx_ff, bidx_in;
   logic [7:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   // Palette rebuild sweep.
   logic        rebuild_ff, rebuild_in;
   logic [3:0]  ridx_ff, ridx_in;

   dlbv_pkg::result_type out_ff, out_in;

   logic        take, can_load, fire;
   logic        pwe;
   logic [2:0]  pwa, pra;
   logic [23:0] pwd, prd;
   logic        look_ff, look_in;
   logic        lkcur_ff, lkcur_in;
   logic [23:0] lkrgb_ff, lkrgb_in;
   logic [3:0]  lkrep_ff, lkrep_in;

   dlbv_palette_ram u_pal (
      .clock(clock), .wr_en(pwe), .wr_addr(pwa), .wr_data(pwd),
      .rd_addr(pra), .rd_data(prd)
   );

   assign can_load = !out_ff.valid || rsp_ready;
   assign req_ready = !burst_ff && !rebuild_ff && !look_ff && can_load;
   assign take = req_valid && req_ready;

   assign rsp_valid  = out_ff.valid;
   assign kind       = out_ff.kind;
   assign address    = out_ff.address;
   assign pixel_rgb  = out_ff.rgb;
   assign repeat_res = out_ff.rep;
   assign row        = out_ff.row;
   assign last       = out_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_start_ff <= dlbv_pkg::LIST_START_RESET;
      end else if (csr_we) begin
         list_start_ff <= csr_wdata;
      end
   end

   always_comb begin
      logic [1:0]  e;
      logic [2:0]  v;
      logic [10:0] rep;
      logic        hit;
      logic [8:0]  nline;
      phase_in = phase_ff; line_in = line_ff; list_in = list_ff; bmap_in = bmap_ff;
      tag1_in = tag1_ff; size_in = size_ff; typ_in = typ_ff; palw_in = palw_ff;
      scale_in = scale_ff; ccol_in = ccol_ff; bank_in = bank_ff; ctype_in = ctype_ff;
      con_in = con_ff; cpos_in = cpos_ff; cbit_in = cbit_ff; left_in = left_ff;
      bpos_in = bpos_ff; burst_in = burst_ff; bidx_in = bidx_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      rebuild_in = rebuild_ff; ridx_in = ridx_ff;
      out_in = out_ff;
      look_in = 1'b0; lkcur_in = lkcur_ff; lkrgb_in = lkrgb_ff;
      lkrep_in = lkrep_ff;
      pwe = 1'b0; pwa = ridx_ff[2:0];
      pwd = dlbv_pkg::colour_lookup(bank_ff | {3'd0, palw_ff[{ridx_ff[2:0], 2'b00} +: 4]});
      pra = 3'd0;
      e = 2'd0; v = 3'd0; rep = 11'd0; hit = 1'b0; nline = line_ff + 9'd1;
      fire = 1'b0;
      if (out_ff.valid && rsp_ready) out_in.valid = 1'b0;

      if (rebuild_ff) begin
         pwe = 1'b1;
         ridx_in = ridx_ff + 4'd1;
         if (ridx_ff == 4'd7) rebuild_in = 1'b0;
      end

      // Result word after a palette read.
      if (look_ff) begin
         out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_PIXEL, address: bmap_ff,
                    rgb: lkcur_ff ? lkrgb_ff : prd, rep: lkrep_ff,
                    row: line_ff - 9'(dlbv_pkg::BlankLines), last: 1'b0};
      end else if (burst_ff && can_load) begin
         if (bidx_ff == 4'd8) begin
            burst_in = 1'b0;
            if (left_ff == 11'd0) begin
               fire = 1'b1;
            end else begin
               bmap_in = bmap_ff + 16'd1;
               bpos_in = bpos_ff + 10'd1;
               out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_PLANE, address: bmap_ff + 16'd1,
                          rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
            end
         end else begin
            v = {p2_ff[bidx_ff[2:0]], p1_ff[bidx_ff[2:0]], p0_ff[bidx_ff[2:0]]};
            hit = con_ff && !cpos_ff[7] && (bpos_ff == {3'd0, cpos_ff[6:0]}) &&
                  (!ctype_ff || bidx_ff[2:0] == cbit_ff);
            pra = v;
            rep = ({7'd0, scale_ff} < left_ff) ? {7'd0, scale_ff} : left_ff;
            left_in = left_ff - rep;
            look_in = 1'b1;
            lkcur_in = hit;
            lkrgb_in = dlbv_pkg::colour_lookup({3'd0, ccol_ff});
            lkrep_in = rep[3:0];
            bidx_in = bidx_ff + 4'd1;
         end
      end

      if (take) begin
         if (!req_type) begin
            line_in = 9'd0; list_in = list_start_ff; bmap_in = 16'd0; size_in = 1'b0;
            typ_in = 1'b0; tag1_in = 16'd0; palw_in = 32'd0; scale_in = 4'd1;
            bank_in = 7'd0; ccol_in = 4'd0; ctype_in = 1'b0; cpos_in = 8'h80;
            cbit_in = 3'd0; con_in = 1'b0; left_in = 11'(dlbv_pkg::LinePixels);
            bpos_in = 10'd0;
            rebuild_in = 1'b1; ridx_in = 4'd0;
            out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_WORD, address: list_start_ff,
                       rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
            list_in = list_start_ff + 16'd2;
            phase_in = dlbv_pkg::PH_BITS;
         end else begin
            unique case (phase_ff)
               dlbv_pkg::PH_TAG1: begin
                  tag1_in = word_data;
                  out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_WORD, address: list_ff,
                             rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
                  list_in = list_ff + 16'd2;
                  phase_in = dlbv_pkg::PH_TAG2;
               end
               dlbv_pkg::PH_TAG2: begin
                  if (typ_ff) begin
                     palw_in = {word_data, tag1_ff};
                  end else begin
                     e = word_data[5:4];
                     bank_in = {~word_data[2:0], 4'd0};
                     ccol_in = tag1_ff[3:0];
                     ctype_in = tag1_ff[4];
                     cpos_in = {1'b0, 7'(tag1_ff[15:8] >> e)};
                     cbit_in = tag1_ff[7:5];
                     scale_in = 4'd1 << e;
                  end
                  rebuild_in = 1'b1; ridx_in = 4'd0;
                  out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_WORD, address: list_ff,
                             rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
                  list_in = list_ff + 16'd2;
                  phase_in = dlbv_pkg::PH_BITS;
               end
               dlbv_pkg::PH_BITS: begin
                  bmap_in = word_data;
                  out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_WORD, address: list_ff,
                             rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
                  phase_in = dlbv_pkg::PH_LINK;
               end
               dlbv_pkg::PH_LINK: begin
                  size_in = word_data[1];
                  if (word_data[1]) begin
                     list_in = {word_data[15:3], 3'd0};
                     typ_in = word_data[2];
                  end else begin
                     list_in = {word_data[15:2], 2'd0};
                  end
                  if (word_data[0]) con_in = ~con_ff;
                  if (line_ff < 9'(dlbv_pkg::BlankLines)) begin
                     fire = 1'b1;
                  end else begin
                     left_in = 11'(dlbv_pkg::LinePixels);
                     bpos_in = 10'd0;
                     out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_PLANE, address: bmap_ff,
                                rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
                     phase_in = dlbv_pkg::PH_PLANE;
                  end
               end
               dlbv_pkg::PH_PLANE: begin
                  p0_in = plane0_byte; p1_in = plane1_byte; p2_in = plane2_byte;
                  burst_in = 1'b1; bidx_in = 4'd0;
               end
               default: ;
            endcase
         end
      end

      // Line end: next line or frame done. list_in already holds the link target.
      if (fire) begin
         line_in = nline;
         if (nline >= 9'(dlbv_pkg::LinesPerFrame)) begin
            out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_DONE, address: 16'd0,
                       rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
            phase_in = dlbv_pkg::PH_IDLE;
         end else begin
            out_in = '{valid: 1'b1, kind: dlbv_pkg::KIND_WORD, address: list_in,
                       rgb: 24'd0, rep: 4'd0, row: 9'd0, last: 1'b1};
            list_in = list_in + 16'd2;
            phase_in = (take ? size_in : size_ff) ? dlbv_pkg::PH_TAG1 : dlbv_pkg::PH_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dlbv_pkg::PH_IDLE;
         burst_ff <= 1'b0;
         rebuild_ff <= 1'b0;
         look_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         burst_ff <= burst_in;
         rebuild_ff <= rebuild_in;
         look_ff <= look_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in; list_ff <= list_in; bmap_ff <= bmap_in; tag1_ff <= tag1_in;
      size_ff <= size_in; typ_ff <= typ_in; palw_ff <= palw_in; scale_ff <= scale_in;
      ccol_ff <= ccol_in; bank_ff <= bank_in; ctype_ff <= ctype_in; con_ff <= con_in;
      cpos_ff <= cpos_in; cbit_ff <= cbit_in; left_ff <= left_in; bpos_ff <= bpos_in;
      bidx_ff <= bidx_in; p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      ridx_ff <= ridx_in; lkcur_ff <= lkcur_in; lkrgb_ff <= lkrgb_in;
      lkrep_ff <= lkrep_in;
   end
endmodule

// ===== hw/rtl/dlbv_palette_ram.sv =====
`timescale 1ns / 1ps
// Eight-entry palette store with a synchronous read port.
module dlbv_palette_ram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [2:0]  wr_addr,
   input  logic [23:0] wr_data,
   input  logic [2:0]  rd_addr,
   output logic [23:0] rd_data
);
   logic [23:0] mem [8];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/dlbv_checker.sv =====
`timescale 1ns / 1ps
module dlbv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [3:0]  repeat_res,
   input logic [8:0]  row,
   input logic        last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind))
      else $error("result word dropped under stall");
   a_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == dlbv_pkg::KIND_PIXEL |-> repeat_res <= 4'd8)
      else $error("run longer than scale");
   a_runlast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == dlbv_pkg::KIND_PIXEL |-> !last)
      else $error("pixel run marked last");
   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != dlbv_pkg::KIND_PIXEL |-> row == 9'd0 && repeat_res == 4'd0)
      else $error("run fields set on non-pixel word");
endmodule

bind display_list_bitplane_video dlbv_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .kind(kind), .repeat_res(repeat_res), .row(row), .last(last)
);

// ===== verif/display_list_bitplane_video_checker.sv =====
`timescale 1ns / 1ps
module display_list_bitplane_video_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] word_data,
   input  logic [7:0]  plane0_byte,
   input  logic [7:0]  plane1_byte,
   input  logic [7:0]  plane2_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  kind,
   input  logic [15:0] address,
   input  logic [23:0] pixel_rgb,
   input  logic [3:0]  repeat_res,
   input  logic [8:0]  row,
   input  logic        last,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          words_pending,
   output int          frames_done,
   output int          words_checked
);

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [23:0] rgb;
      logic [3:0]  rep;
      logic [8:0]  row;
      logic        last;
   } video_word_type;

   video_word_type expected_words[$];
   video_word_type step_words[$];

   logic [15:0] list_start;
   logic [8:0]  line_cnt;
   dlbv_pkg::phase_type phase;
   logic [15:0] list_addr;
   logic [15:0] bitmap_addr;
   logic        size_flag;
   logic        type_flag;
   logic [15:0] tag_one;
   logic [31:0] palette_bits;
   logic [3:0]  scale;
   logic [6:0]  bank;
   logic [3:0]  cur_colour;
   logic        cur_type;
   logic [7:0]  cur_pos;
   logic [2:0]  cur_bit;
   logic        cur_on;
   logic [23:0] palette [8];
   logic [9:0]  pix_left;
   logic [9:0]  byte_pos;

   // Bit 4 dims blue, bit 5 green, bit 6 red; bit 3 selects the bright level.
   function automatic logic [23:0] colour_of(input logic [6:0] idx);
      logic [7:0] c [3];
      for (int k = 0; k < 3; k++) begin
         if (!idx[k]) c[k] = 8'h00;
         else if (idx[3]) c[k] = idx[4+k] ? 8'hDF : 8'hFF;
         else c[k] = idx[4+k] ? 8'h60 : 8'h80;
      end
      return {c[2], c[1], c[0]};
   endfunction

   task automatic add_word(input logic [1:0] k, input logic [15:0] a,
                           input logic [23:0] c, input logic [3:0] r,
                           input logic [8:0] rw);
      video_word_type w;
      w.kind = k; w.address = a; w.rgb = c; w.rep = r; w.row = rw; w.last = 1'b0;
      step_words.insert(step_words.size(), w);
   endtask

   task automatic start_frame();
      line_cnt = '0; list_addr = list_start; bitmap_addr = '0;
      size_flag = 0; type_flag = 0; tag_one = '0; palette_bits = '0;
      scale = 4'd1; bank = '0; cur_colour = '0; cur_type = 0;
      cur_pos = 8'd128; cur_bit = '0; cur_on = 0;
      for (int i = 0; i < 8; i++) palette[i] = '0;
      pix_left = 10'(dlbv_pkg::LinePixels); byte_pos = '0;
   endtask

   task automatic fetch_word(input dlbv_pkg::phase_type next);
      add_word(dlbv_pkg::KIND_WORD, list_addr, '0, '0, '0);
      phase = next;
   endtask

   task automatic open_line();
      fetch_word(size_flag ? dlbv_pkg::PH_TAG1 : dlbv_pkg::PH_BITS);
      list_addr = list_addr + 16'd2;
   endtask

   task automatic close_line();
      line_cnt = line_cnt + 9'd1;
      if (line_cnt >= 9'(dlbv_pkg::LinesPerFrame)) begin
         add_word(dlbv_pkg::KIND_DONE, '0, '0, '0, '0);
         phase = dlbv_pkg::PH_IDLE;
         frames_done++;
      end else begin
         open_line();
      end
   endtask

   task automatic load_tags(input logic [15:0] t1, input logic [15:0] t2);
      logic [1:0] e;
      e = t2[5:4];
      if (type_flag) begin
         palette_bits = {t2, t1};
      end else begin
         bank = {3'd7 - t2[2:0], 4'd0};
         cur_colour = t1[3:0];
         cur_type = t1[4];
         cur_pos = {1'b0, 7'((t1 >> 8) >> e)};
         cur_bit = t1[7:5];
         scale = 4'd1 << e;
      end
      for (int c = 0; c < 8; c++)
         palette[c] = colour_of(bank | 7'(palette_bits[c*4 +: 4]));
   endtask

   task automatic predict(input logic typ, input logic [15:0] w,
                          input logic [7:0] p0, input logic [7:0] p1,
                          input logic [7:0] p2);
      logic [23:0] c;
      logic [3:0]  r;
      logic [8:0]  rw;
      step_words.delete();
      if (!typ) begin
         start_frame();
         open_line();
      end else begin
         case (phase)
            dlbv_pkg::PH_TAG1: begin
               tag_one = w;
               fetch_word(dlbv_pkg::PH_TAG2);
               list_addr = list_addr + 16'd2;
            end
            dlbv_pkg::PH_TAG2: begin
               load_tags(tag_one, w);
               fetch_word(dlbv_pkg::PH_BITS);
               list_addr = list_addr + 16'd2;
            end
            dlbv_pkg::PH_BITS: begin
               bitmap_addr = w;
               fetch_word(dlbv_pkg::PH_LINK);
            end
            dlbv_pkg::PH_LINK: begin
               size_flag = w[1];
               if (size_flag) begin
                  list_addr = w & 16'hFFF8;
                  type_flag = w[2];
               end else begin
                  list_addr = w & 16'hFFFC;
               end
               if (w[0]) cur_on = ~cur_on;
               if (line_cnt < 9'(dlbv_pkg::BlankLines)) begin
                  close_line();
               end else begin
                  pix_left = 10'(dlbv_pkg::LinePixels);
                  byte_pos = '0;
                  add_word(dlbv_pkg::KIND_PLANE, bitmap_addr, '0, '0, '0);
                  phase = dlbv_pkg::PH_PLANE;
               end
            end
            dlbv_pkg::PH_PLANE: begin
               rw = line_cnt - 9'(dlbv_pkg::BlankLines);
               for (int b = 0; b < 8; b++) begin
                  if (cur_on && {2'b0, cur_pos} == byte_pos && (!cur_type || b == cur_bit))
                     c = colour_of({3'd0, cur_colour});
                  else
                     c = palette[{p2[b], p1[b], p0[b]}];
                  r = (10'(scale) < pix_left) ? scale : 4'(pix_left);
                  pix_left = pix_left - 10'(r);
                  add_word(dlbv_pkg::KIND_PIXEL, bitmap_addr, c, r, rw);
               end
               if (pix_left == 0) begin
                  close_line();
               end else begin
                  bitmap_addr = bitmap_addr + 16'd1;
                  byte_pos = byte_pos + 10'd1;
                  add_word(dlbv_pkg::KIND_PLANE, bitmap_addr, '0, '0, '0);
               end
            end
            default: ;
         endcase
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
      foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
   endtask

   task automatic report(input string what, input video_word_type e);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t mismatch %s: exp kind %0d addr %h rgb %h rep %0d row %0d last %0d",
                  $realtime, what, e.kind, e.address, e.rgb, e.rep, e.row, e.last);
         $display("   got kind %0d addr %h rgb %h rep %0d row %0d last %0d",
                  kind, address, pixel_rgb, repeat_res, row, last);
      end
   endtask

   initial begin
      fail_count = 0; frames_done = 0; words_checked = 0;
      list_start = dlbv_pkg::LIST_START_RESET;
      phase = dlbv_pkg::PH_IDLE;
      start_frame();
   end

   assign words_pending = expected_words.size();

   always @(posedge clock) begin
      video_word_type e;
      if (reset) begin
         list_start = dlbv_pkg::LIST_START_RESET;
         start_frame();
         phase = dlbv_pkg::PH_IDLE;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready)
            predict(req_type, word_data, plane0_byte, plane1_byte, plane2_byte);
         if (csr_we) list_start = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               e = '{default: '0};
               report("unexpected word", e);
            end else begin
               e = expected_words.pop_front();
               if (e.kind !== kind || e.address !== address || e.rgb !== pixel_rgb ||
                   e.rep !== repeat_res || e.row !== row || e.last !== last)
                  report("field", e);
            end
         end
      end
   end

endmodule

// ===== verif/display_list_bitplane_video_tb.sv =====
`timescale 1ns / 1ps
module display_list_bitplane_video_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_type = 0;
   logic [15:0] word_data = '0;
   logic [7:0]  plane0_byte = '0;
   logic [7:0]  plane1_byte = '0;
   logic [7:0]  plane2_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  kind;
   logic [15:0] address;
   logic [23:0] pixel_rgb;
   logic [3:0]  repeat_res;
   logic [8:0]  row;
   logic        last;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;

   int fail_count, words_pending, frames_done, words_checked;
   int burst_left = 0;
   int sent_words = 0;

   display_list_bitplane_video i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .word_data(word_data), .plane0_byte(plane0_byte), .plane1_byte(plane1_byte),
      .plane2_byte(plane2_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .kind(kind), .address(address),
      .pixel_rgb(pixel_rgb), .repeat_res(repeat_res), .row(row), .last(last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   display_list_bitplane_video_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .word_data(word_data), .plane0_byte(plane0_byte), .plane1_byte(plane1_byte),
      .plane2_byte(plane2_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .kind(kind), .address(address),
      .pixel_rgb(pixel_rgb), .repeat_res(repeat_res), .row(row), .last(last),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .words_pending(words_pending),
      .frames_done(frames_done), .words_checked(words_checked)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // The receiver alternates between stretches where it is always ready and
   // stretches where it stalls at random, so stalls land on every output phase.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) < 55);
   end

   // Wait until the checker holds no expectation. The count is read at the
   // falling edge so that it never races with the checker's update.
   task automatic wait_drain();
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Present one word and hold it until taken. Valid stays high across a
   // burst; at the end of a burst it drops for a random gap. When drain is
   // set the sender also waits for every expected result to come back.
   task automatic send_word(input logic typ, input logic [15:0] w, input logic [7:0] p0,
                            input logic [7:0] p1, input logic [7:0] p2, input bit drain);
      req_valid <= 1'b1;
      req_type <= typ;
      word_data <= w;
      plane0_byte <= p0;
      plane1_byte <= p1;
      plane2_byte <= p2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_words++;
      if (burst_left > 0 && !drain) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(0, 6);
         repeat ($urandom_range(1, 4)) @(posedge clock);
         if (drain) wait_drain();
      end
   endtask

   task automatic send_reply(input logic [15:0] w, input bit drain);
      send_word(1'b1, w, 8'($urandom), 8'($urandom), 8'($urandom), drain);
   endtask

   // A register write happens only with the block idle: drop valid, drain,
   // then let a few cycles pass in case an ignored word is still in flight.
   task automatic write_list_start(input logic [15:0] v);
      req_valid <= 1'b0;
      wait_drain();
      repeat (12) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Word data for random frames: the link word asks for tags now and then so
   // that palettes, scales and the cursor are exercised, while enough words
   // are left to pass the blank lines and reach pixel output.
   function automatic logic [15:0] list_word();
      logic [15:0] w;
      w = 16'($urandom);
      w[1] = ($urandom_range(0, 99) < 40);
      return w;
   endfunction

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Replies while idle are ignored and must cause nothing.
      send_reply(16'hFFFF, 1);
      send_reply(16'h0000, 1);

      // Directed frame at the reset list start: extreme words through the
      // blank lines, then a frame start while the first frame is busy.
      send_word(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 1);
      send_reply(16'h0000, 1);
      send_reply(16'hFFFF, 1);
      send_reply(16'h0000, 1);
      send_reply(16'h0007, 1);
      send_reply(16'h00FF, 1);
      send_reply(16'hFF00, 1);
      send_word(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1);

      write_list_start(16'h0000);
      write_list_start(16'hFFFF);

      // Random frame, long enough to pass the blank lines and reach pixel
      // output. Some words go out without draining to keep overlap.
      send_word(1'b0, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
      n = $urandom_range(75, 85);
      for (int i = 0; i < n; i++)
         send_reply(list_word(), $urandom_range(0, 99) < 70);
      write_list_start(16'($urandom));

      // A new frame at the written list start abandons the busy one.
      send_word(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 1);
      for (int i = 0; i < 10; i++) send_reply(list_word(), 0);

      req_valid <= 1'b0;
      wait_drain();
      repeat (30) @(posedge clock);

      $display("Sent %0d input words and checked %0d output words; %0d frames ran to the end.",
               sent_words, words_checked, frames_done);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Safety net against a hang.
   initial begin
      #8ms;
      $display("Timeout with %0d words still expected.", words_pending);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dlbv_pkg.sv
hw/rtl/dlbv_palette_ram.sv
hw/rtl/display_list_bitplane_video.sv
hw/rtl/dlbv_checker.sv
verif/display_list_bitplane_video_checker.sv
verif/display_list_bitplane_video_tb.sv
